// File: hw/rtl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg: shared types and constants for the perfect number tester
// Holds field widths, the controller state type and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package pnt_pkg;

	localparam int VALUE_WIDTH_DEF = 32;  // default operand width
	localparam int IN_W            = 32;  // width of the value and echo ports
	localparam int SUM_W           = 36;  // width of the divisor sum port

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;      // take a new value, start the first division
		logic div_step;  // one restoring divide step
		logic check;     // test the candidate, accumulate, start the next one
		logic finish;    // close the sum and register the result
	} cmd_t;

	typedef struct packed {
		logic div_last;  // last divide step in progress
		logic loop_end;  // candidate exceeds its cofactor
	} sts_t;

endpackage

// File: hw/rtl/pnt_ctrl.sv
// ----------------------------------------------------------------------------
// pnt_ctrl: sequencer for the perfect number tester
// Steps the datapath through one division per candidate divisor, the
// candidate check and the final result transfer.
// ----------------------------------------------------------------------------
module pnt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pnt_pkg::sts_t sts,
	output pnt_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	pnt_pkg::state_t state_q;
	pnt_pkg::state_t state_d;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnt_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pnt_pkg::ST_FINISH);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pnt_pkg::ST_IDLE: begin
				if (start) state_d = pnt_pkg::ST_DIVIDE;
			end
			pnt_pkg::ST_DIVIDE: begin
				if (sts.div_last) state_d = pnt_pkg::ST_CHECK;
			end
			pnt_pkg::ST_CHECK: begin
				state_d = sts.loop_end ? pnt_pkg::ST_FINISH : pnt_pkg::ST_DIVIDE;
			end
			pnt_pkg::ST_FINISH: begin
				state_d = pnt_pkg::ST_IDLE;
			end
			default: begin
				state_d = pnt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			pnt_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			pnt_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			pnt_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
			end
			pnt_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	a_check_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pnt_pkg::ST_CHECK && !sts.loop_end) |=> state_q == pnt_pkg::ST_DIVIDE)
		else $error("next candidate not started");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == pnt_pkg::ST_FINISH)
		else $error("result strobe without finish step");

endmodule

// File: hw/rtl/pnt_dp.sv
// ----------------------------------------------------------------------------
// pnt_dp: datapath of the perfect number tester
// Restoring divider (one quotient bit per cycle), candidate counter,
// divisor sum accumulator and the result registers.
// ----------------------------------------------------------------------------
module pnt_dp #(
	parameter int VALUE_WIDTH = pnt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pnt_pkg::cmd_t             cmd,
	output pnt_pkg::sts_t             sts,
	input  logic [pnt_pkg::IN_W-1:0]  value,
	output logic [pnt_pkg::IN_W-1:0]  tested_value,
	output logic                      is_perfect,
	output logic [pnt_pkg::SUM_W-1:0] divisor_sum
);

	localparam int W      = VALUE_WIDTH;
	localparam int CNT_W  = $clog2(W);
	// sigma(n) stays below 16n for any operand up to 64 bits
	localparam int ACC_W  = W + 4;
	localparam int VEXT_W = (W > pnt_pkg::IN_W) ? W : pnt_pkg::IN_W;
	localparam int SEXT_W = (ACC_W > pnt_pkg::SUM_W) ? ACC_W : pnt_pkg::SUM_W;

	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] acc_q;

	logic [VEXT_W-1:0] value_ext;
	logic [W-1:0]      n_in;
	logic [W:0]        trial;
	logic [W:0]        diff;
	logic              qbit;
	logic [ACC_W-1:0]  addend;
	logic [ACC_W-1:0]  sum_c;
	logic              perfect_c;
	logic [VEXT_W-1:0] echo_ext;
	logic [SEXT_W-1:0] sum_ext;

	assign value_ext = VEXT_W'(value);
	assign n_in      = value_ext[W-1:0];

	// shift the next dividend bit into the partial remainder and try subtracting
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign qbit  = !diff[W];

	// add the divisor, and the cofactor when it is a different divisor
	assign addend = ACC_W'(d_q) + ((quo_q != d_q) ? ACC_W'(quo_q) : ACC_W'(0));

	// the pair for candidate one counted the value itself: drop it
	assign sum_c     = acc_q - ACC_W'(n_q);
	assign perfect_c = (n_q != '0) && (sum_c == ACC_W'(n_q));
	assign echo_ext  = VEXT_W'(n_q);
	assign sum_ext   = SEXT_W'(sum_c);

	assign sts.div_last = (cnt_q == '0);
	assign sts.loop_end = (d_q > quo_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_in;
			d_q   <= W'(1);
			rem_q <= '0;
			quo_q <= n_in;
			cnt_q <= CNT_W'(W - 1);
			acc_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], qbit};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cmd.check && !sts.loop_end) begin
			if (rem_q == '0) acc_q <= acc_q + addend;
			d_q   <= d_q + W'(1);
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= CNT_W'(W - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tested_value <= echo_ext[pnt_pkg::IN_W-1:0];
			is_perfect   <= perfect_c;
			divisor_sum  <= sum_ext[pnt_pkg::SUM_W-1:0];
		end
	end

	a_cand_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> d_q != '0)
		else $error("candidate divisor is zero");

	a_cnt_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && cnt_q != '0) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("divide step counter out of sequence");

	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> rem_q < d_q)
		else $error("remainder not below divisor");

endmodule

// File: hw/rtl/perfect_number_test.sv
// ----------------------------------------------------------------------------
// perfect_number_test: aliquot sum and perfect number check
// Sums the proper divisors of a value and flags the value when they add up
// to the value itself.
// ----------------------------------------------------------------------------
// Usage:
//   Drive value and raise start; the transfer happens on the edge where start
//   is high and busy is low. busy stays high until the item is finished.
//   One result comes back per item: done is high for exactly one cycle with
//   tested_value, is_perfect and divisor_sum valid in that cycle. The result
//   ports hold their contents until the next result; the receiver cannot
//   stall them, so it must take the result in the done cycle.
//   Candidates d are tried from 1 while d <= value / d; each candidate goes
//   through the bit-serial restoring divider and then a check step, so the
//   time from transfer to done grows with VALUE_WIDTH and with sqrt(value).
//   A new item may be started in the cycle done is high.
//   Reset clears the sequencer: busy and done go low, no result is pending.
// ----------------------------------------------------------------------------
module perfect_number_test #(
	parameter int VALUE_WIDTH = pnt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [pnt_pkg::IN_W-1:0]  value,
	output logic                      done,
	output logic [pnt_pkg::IN_W-1:0]  tested_value,
	output logic                      is_perfect,
	output logic [pnt_pkg::SUM_W-1:0] divisor_sum
);

	pnt_pkg::cmd_t cmd;
	pnt_pkg::sts_t sts;

	pnt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pnt_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.tested_value (tested_value),
		.is_perfect   (is_perfect),
		.divisor_sum  (divisor_sum)
	);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for perfect_number_test
// Sends positive integers through the start/busy command port and checks every
// done-strobed result against an aliquot sum worked out in the bench. The
// values are mostly small, so each item tries few candidate divisors. A few
// large values and the full-width extreme exercise the long division runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int IN_W  = pnt_pkg::IN_W;
	localparam int SUM_W = pnt_pkg::SUM_W;

	typedef struct {
		logic [IN_W-1:0]  tested_value;
		logic             is_perfect;
		logic [SUM_W-1:0] divisor_sum;
	} divisor_result_t;

	// Predicts one result per accepted value and checks results in order.
	class aliquot_checker;
		divisor_result_t sums_due[$];
		int unsigned     mismatches;
		int unsigned     checked;
		int unsigned     perfect_seen;

		function new();
			mismatches   = 0;
			checked      = 0;
			perfect_seen = 0;
		endfunction

		// Pair each divisor d with v / d up to the square root.
		function logic [SUM_W-1:0] proper_divisor_total(logic [IN_W-1:0] v);
			longint unsigned n;
			longint unsigned d;
			longint unsigned total;
			n     = v;
			total = 0;
			if (n == 0)
				return '0;
			for (d = 1; d <= n / d; d++) begin
				if (n % d == 0) begin
					total += d;
					if (n / d != d)
						total += n / d;
				end
			end
			// drop the value itself, added along with divisor 1
			return SUM_W'(total - n);
		endfunction

		function void note_value(logic [IN_W-1:0] v);
			divisor_result_t r;
			r.tested_value = v;
			r.divisor_sum  = proper_divisor_total(v);
			r.is_perfect   = (v != 0) && (r.divisor_sum == SUM_W'(v));
			sums_due.push_back(r);
		endfunction

		function void check_result(logic [IN_W-1:0] tv, logic perf, logic [SUM_W-1:0] sum);
			divisor_result_t r;
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected result: value %0d perfect %0b sum %0d",
					$time, tv, perf, sum);
				mismatches++;
				return;
			end
			r = sums_due.pop_front();
			checked++;
			if (r.is_perfect)
				perfect_seen++;
			if (tv !== r.tested_value) begin
				$display("%0t: tested_value mismatch: expected %0d actual %0d",
					$time, r.tested_value, tv);
				mismatches++;
			end
			if (perf !== r.is_perfect) begin
				$display("%0t: is_perfect mismatch for %0d: expected %0b actual %0b",
					$time, r.tested_value, r.is_perfect, perf);
				mismatches++;
			end
			if (sum !== r.divisor_sum) begin
				$display("%0t: divisor_sum mismatch for %0d: expected %0d actual %0d",
					$time, r.tested_value, r.divisor_sum, sum);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [IN_W-1:0]  value;
	logic             done;
	logic [IN_W-1:0]  tested_value;
	logic             is_perfect;
	logic [SUM_W-1:0] divisor_sum;

	aliquot_checker board = new();
	int unsigned    values_sent;
	logic [IN_W-1:0] largest_sent;

	perfect_number_test u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.done         (done),
		.tested_value (tested_value),
		.is_perfect   (is_perfect),
		.divisor_sum  (divisor_sum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results cannot be held off: take each one in its done cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(tested_value, is_perfect, divisor_sum);
	end

	// Idle with start low when gap is nonzero, then hold start until the transfer.
	task automatic send_value(logic [IN_W-1:0] v, int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		value = v;
		do
			@(posedge clk);
		while (busy);
		board.note_value(v);
		values_sent++;
		if (v > largest_sent)
			largest_sent = v;
	endtask

	initial begin
		logic [IN_W-1:0] directed_values[$];
		logic [IN_W-1:0] v;
		int unsigned     w;
		int unsigned     gap;
		int unsigned     pick;

		arst_n       = 1'b0;
		start        = 1'b0;
		value        = '0;
		values_sent  = 0;
		largest_sent = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one, primes, squares, abundant numbers, the known perfect numbers
		// and the all-ones extreme
		directed_values = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12,
			32'd28, 32'd97, 32'd496, 32'd945, 32'd1024, 32'd8128, 32'h5555,
			32'hAAAA, 32'd65521, 32'd16777215, 32'd33550336, 32'hFFFF_FFFF};
		foreach (directed_values[i])
			send_value(directed_values[i], (i % 3 == 0) ? 0 : $urandom_range(0, 19));

		for (int i = 0; i < 100; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				case ($urandom_range(0, 3))
					0: v = 32'd6;
					1: v = 32'd28;
					2: v = 32'd496;
					default: v = 32'd8128;
				endcase
			end else if (pick == 1) begin
				// perfect square: the paired divisor is its own cofactor
				w = $urandom_range(1, 180);
				v = IN_W'(w * w);
			end else begin
				w = $urandom_range(1, 20);
				v = $urandom & ((32'd1 << w) - 1);
				if (v == 0)
					v = 32'd1;
			end
			// alternate stretches of back-to-back transfers with random idling
			gap = ((i / 16) % 2 == 1) ? 0 : $urandom_range(0, 19);
			send_value(v, gap);
		end

		@(negedge clk);
		start = 1'b0;
		while (board.sums_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d values up to %0d; checked %0d results, %0d of them perfect.",
			values_sent, largest_sent, board.checked, board.perfect_seen);
		if (board.mismatches == 0 && board.sums_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing",
				board.mismatches, board.sums_due.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#300_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, board.sums_due.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pnt_pkg.sv
hw/rtl/pnt_ctrl.sv
hw/rtl/pnt_dp.sv
hw/rtl/perfect_number_test.sv
tb/tb.sv
